/* rtl/gzhs_pkg.sv */
// gzhs_pkg: shared types and constants for the gzip header skipper
// request payload structs, result kinds, flag masks and queue sizing
// no dependencies
`timescale 1ns / 1ps

package gzhs_pkg;

    // default width of the internal header byte counter
    localparam int GZHS_OFFSET_BITS = 24;

    // depth of the queue between front and back
    localparam int GZHS_QUEUE_DEPTH = 2;

    // gzip header constants
    localparam logic [7:0] GZ_METHOD_DEFLATE = 8'h08;
    localparam logic [7:0] GZ_RESERVED       = 8'he0;
    localparam logic [4:0] GZ_FHCRC          = 5'h02;
    localparam logic [4:0] GZ_FEXTRA         = 5'h04;
    localparam logic [4:0] GZ_FNAME          = 5'h08;
    localparam logic [4:0] GZ_FCOMMENT       = 5'h10;
    localparam logic [3:0] GZ_FIXED_LEN      = 4'd10;

    // saturation limit of the reported header length
    localparam int         HL_WIDTH = 24;
    localparam logic [23:0] HL_MAX  = 24'hffffff;

    // result kinds
    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_BAD     = 2'd2,
        KIND_TRUNC   = 2'd3
    } kind_t;

    // input request
    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
    } gzhs_in_t;

    // result request
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  payload;
        logic [23:0] header_length;
        logic        end_mark;
    } gzhs_out_t;

    // queue entry: the byte plus its precomputed classification
    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
        logic       is_zero;
        logic       is_deflate;
        logic       has_reserved;
    } gzhs_entry_t;

endpackage

/* rtl/gzhs_front.sv */
// gzhs_front: accepts input requests, classifies each byte and queues it
// small fifo toward the parser back end
// depends on gzhs_pkg
`timescale 1ns / 1ps

module gzhs_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  gzhs_pkg::gzhs_in_t   in_data,
    output logic                 q_valid,
    input  logic                 q_pop,
    output gzhs_pkg::gzhs_entry_t q_head
);
    import gzhs_pkg::*;

    localparam int PTR_BITS = (GZHS_QUEUE_DEPTH > 1) ? $clog2(GZHS_QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(GZHS_QUEUE_DEPTH + 1);
    localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(GZHS_QUEUE_DEPTH);
    localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(GZHS_QUEUE_DEPTH - 1);

    gzhs_entry_t         mem_reg [GZHS_QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    gzhs_entry_t         entry;
    logic                push;

    // classify the incoming byte
    always_comb
    begin
        entry.data_byte    = in_data.data_byte;
        entry.first_byte   = in_data.first_byte;
        entry.last_byte    = in_data.last_byte;
        entry.is_zero      = (in_data.data_byte == 8'd0);
        entry.is_deflate   = (in_data.data_byte == GZ_METHOD_DEFLATE);
        entry.has_reserved = ((in_data.data_byte & GZ_RESERVED) != 8'd0);
    end

    // handshake and pointer updates
    assign in_ready = (count_reg != CNT_FULL);
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != '0);
    assign q_head   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : PTR_BITS'(wr_ptr_reg + 1'b1);
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : PTR_BITS'(rd_ptr_reg + 1'b1);
        end
        if (push && !q_pop)
        begin
            count_next = CNT_BITS'(count_reg + 1'b1);
        end
        else if (!push && q_pop)
        begin
            count_next = CNT_BITS'(count_reg - 1'b1);
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= entry;
        end
    end

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("queue count above depth");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("pop from empty queue");

    a_count_grows: assert property (@(posedge clk) disable iff (!rst_n)
        push && !q_pop |=> count_reg == CNT_BITS'($past(count_reg) + 1'b1))
        else $error("queue count did not follow a push");

endmodule

/* rtl/gzhs_back.sv */
// gzhs_back: header walker that consumes queued bytes and drives results
// holds the parse state and the output register
// depends on gzhs_pkg
`timescale 1ns / 1ps

module gzhs_back #(
    parameter int OFFSET_BITS = gzhs_pkg::GZHS_OFFSET_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    output logic                  q_pop,
    input  gzhs_pkg::gzhs_entry_t q_head,
    output logic                  out_valid,
    input  logic                  out_ready,
    output gzhs_pkg::gzhs_out_t   out_data
);
    import gzhs_pkg::*;

    typedef enum logic [3:0] {
        PH_FIXED   = 4'd0,
        PH_XLEN_LO = 4'd1,
        PH_XLEN_HI = 4'd2,
        PH_XDATA   = 4'd3,
        PH_NAME    = 4'd4,
        PH_COMMENT = 4'd5,
        PH_HCRC    = 4'd6,
        PH_PAYLOAD = 4'd7
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [3:0]             fc_reg, fc_next;
    logic [4:0]             flags_reg, flags_next;
    logic [15:0]            extra_reg, extra_next;
    logic [OFFSET_BITS-1:0] off_reg, off_next;
    kind_t                  err_reg, err_next;
    logic                   out_valid_reg;
    gzhs_out_t              out_data_reg, out_data_next;

    phase_t                 ph;
    logic [3:0]             fc;
    logic [4:0]             fl;
    logic [15:0]            er;
    logic [OFFSET_BITS-1:0] off;
    kind_t                  err;
    logic [3:0]             fc_inc;
    logic [15:0]            er_dec;
    logic [15:0]            er_full;
    logic [32:0]            off_ext;

    // first section at or after a given stage that the flags ask for
    function automatic phase_t next_section(input phase_t from, input logic [4:0] f);
        phase_t r;
        if (from <= PH_XLEN_LO && (f & GZ_FEXTRA) != 5'd0)
        begin
            r = PH_XLEN_LO;
        end
        else if (from <= PH_NAME && (f & GZ_FNAME) != 5'd0)
        begin
            r = PH_NAME;
        end
        else if (from <= PH_COMMENT && (f & GZ_FCOMMENT) != 5'd0)
        begin
            r = PH_COMMENT;
        end
        else if (from <= PH_HCRC && (f & GZ_FHCRC) != 5'd0)
        begin
            r = PH_HCRC;
        end
        else
        begin
            r = PH_PAYLOAD;
        end
        return r;
    endfunction

    // pop when the output register is free or being drained
    assign q_pop     = q_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // state seen by this byte: a first mark restarts from reset
    always_comb
    begin
        if (q_head.first_byte)
        begin
            ph  = PH_FIXED;
            fc  = '0;
            fl  = '0;
            er  = '0;
            off = '0;
            err = KIND_HEADER;
        end
        else
        begin
            ph  = phase_reg;
            fc  = fc_reg;
            fl  = flags_reg;
            er  = extra_reg;
            off = off_reg;
            err = err_reg;
        end
    end

    assign fc_inc  = 4'(fc + 4'd1);
    assign er_dec  = 16'(er - 16'd1);
    assign er_full = {q_head.data_byte, er[7:0]};

    // one step of the header walk
    always_comb
    begin
        phase_next = ph;
        fc_next    = fc;
        flags_next = fl;
        extra_next = er;
        off_next   = off;
        err_next   = err;
        out_data_next.kind     = err;
        out_data_next.payload  = 8'd0;
        out_data_next.end_mark = q_head.last_byte;

        if (err != KIND_HEADER)
        begin
            out_data_next.kind = err;
        end
        else if (ph == PH_PAYLOAD)
        begin
            out_data_next.kind    = KIND_PAYLOAD;
            out_data_next.payload = q_head.data_byte;
        end
        else
        begin
            if (off != '1)
            begin
                off_next = OFFSET_BITS'(off + 1'b1);
            end
            case (ph)
                PH_FIXED:
                begin
                    if (fc == 4'd2 && !q_head.is_deflate)
                    begin
                        err_next = KIND_BAD;
                    end
                    if (fc == 4'd3)
                    begin
                        if (q_head.has_reserved)
                        begin
                            err_next = KIND_BAD;
                        end
                        flags_next = q_head.data_byte[4:0];
                    end
                    fc_next = fc_inc;
                    if (fc_inc >= GZ_FIXED_LEN)
                    begin
                        fc_next    = '0;
                        phase_next = next_section(PH_XLEN_LO, flags_next);
                    end
                end
                PH_XLEN_LO:
                begin
                    extra_next = {8'd0, q_head.data_byte};
                    phase_next = PH_XLEN_HI;
                end
                PH_XLEN_HI:
                begin
                    extra_next = er_full;
                    phase_next = (er_full != 16'd0) ? PH_XDATA : next_section(PH_NAME, fl);
                end
                PH_XDATA:
                begin
                    extra_next = er_dec;
                    if (er_dec == 16'd0)
                    begin
                        phase_next = next_section(PH_NAME, fl);
                    end
                end
                PH_NAME:
                begin
                    if (q_head.is_zero)
                    begin
                        phase_next = next_section(PH_COMMENT, fl);
                    end
                end
                PH_COMMENT:
                begin
                    if (q_head.is_zero)
                    begin
                        phase_next = next_section(PH_HCRC, fl);
                    end
                end
                PH_HCRC:
                begin
                    if (fc == 4'd0)
                    begin
                        fc_next = 4'd1;
                    end
                    else
                    begin
                        fc_next    = '0;
                        phase_next = PH_PAYLOAD;
                    end
                end
                default:
                begin
                    phase_next = PH_PAYLOAD;
                end
            endcase
            // entering the header crc always starts at its first byte
            if (phase_next == PH_HCRC && ph != PH_HCRC)
            begin
                fc_next = '0;
            end
            if (err_next == KIND_HEADER && q_head.last_byte)
            begin
                err_next = KIND_TRUNC;
            end
            out_data_next.kind = err_next;
        end

        // report the count, saturated to the result width
        off_ext = 33'(off_next);
        out_data_next.header_length = (off_ext > 33'(HL_MAX)) ? HL_MAX
                                                               : off_ext[HL_WIDTH-1:0];
    end

    // parse state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_FIXED;
            fc_reg        <= '0;
            flags_reg     <= '0;
            extra_reg     <= '0;
            off_reg       <= '0;
            err_reg       <= KIND_HEADER;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                phase_reg     <= phase_next;
                fc_reg        <= fc_next;
                flags_reg     <= flags_next;
                extra_reg     <= extra_next;
                off_reg       <= off_next;
                err_reg       <= err_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // checks
    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop && err_reg != KIND_HEADER && !q_head.first_byte
        |=> err_reg == $past(err_reg))
        else $error("error code changed without a new stream");

    a_off_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop && !q_head.first_byte |=> off_reg >= $past(off_reg))
        else $error("header count went backward");

    a_payload_only: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.kind != KIND_PAYLOAD |-> out_data_reg.payload == 8'd0)
        else $error("payload byte on a non-payload result");

endmodule

/* rtl/gzip_header_skipper_top.sv */
// gzip header skipper: one result per input byte
// an accepted byte is stored in the queue, then its result is registered in the back end output register
// throughput: one byte per cycle while out_ready does not stall the output, set by the phase update in the back end
// a two-entry queue decouples input acceptance from result stalls
// reset: asynchronous, clears parse state, queue and output valid; no clearing pass
`timescale 1ns / 1ps

module gzip_header_skipper_top #(
    parameter int OFFSET_BITS = gzhs_pkg::GZHS_OFFSET_BITS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  gzhs_pkg::gzhs_in_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output gzhs_pkg::gzhs_out_t out_data
);
    import gzhs_pkg::*;

    logic        q_valid;
    logic        q_pop;
    gzhs_entry_t q_head;

    // byte intake and classification
    gzhs_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_head   (q_head)
    );

    // header walk and result register
    gzhs_back #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_head    (q_head),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
